[rtl/mpae_pkg.sv]
`timescale 1ns / 1ps
package mpae_pkg;

  // Plane and window limits
  localparam int unsigned MaxSide     = 64;
  localparam int unsigned PlaneCells  = MaxSide * MaxSide;
  localparam int unsigned PlaneAw     = $clog2(PlaneCells);
  localparam int unsigned MaxOutSide  = 128;
  localparam int unsigned MaskCells   = MaxOutSide * MaxOutSide;
  localparam int unsigned MaskAw      = $clog2(MaskCells);
  localparam int unsigned MaxFilter   = 8;
  localparam int unsigned WinCntW     = $clog2(MaxFilter);

  localparam int unsigned GradW       = 24;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned IndexW      = 20;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 7;

  // Request kinds
  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindPool  = 2'd1;
  localparam logic [1:0] KindGrad  = 2'd2;
  localparam logic [1:0] KindRead  = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgFilterH = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFilterW = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStrideR = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStrideC = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPadR    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPadC    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgInH     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgInW     = 3'd7;

  // Controller states
  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DECODE = 9'b000000100,
    ST_POOL   = 9'b000001000,
    ST_DRAIN  = 9'b000010000,
    ST_PFIN   = 9'b000100000,
    ST_MRD    = 9'b001000000,
    ST_GADD   = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic item_take;
    logic pix_wr;
    logic grad_zero_wr;
    logic grad_rd_item;
    logic mask_rd;
    logic pool_init;
    logic pool_step;
    logic mask_wr;
    logic grad_rd_mask;
    logic grad_sat_wr;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       clr_done;
    logic [1:0] kind;
    logic       plane_ok;
    logic       out_ok;
    logic       cells_last;
    logic       mask_valid;
    logic       out_free;
  } sts_t;

endpackage

[rtl/mpae_ctrl.sv]
`timescale 1ns / 1ps
module mpae_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mpae_pkg::sts_t  sts_i,
  output mpae_pkg::cmd_t  cmd_o
);

  mpae_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpae_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == mpae_pkg::ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      mpae_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = mpae_pkg::ST_IDLE;
      end
      mpae_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_take = 1'b1;
          state_d         = mpae_pkg::ST_DECODE;
        end
      end
      mpae_pkg::ST_DECODE: begin
        state_d = mpae_pkg::ST_IDLE;
        case (sts_i.kind)
          mpae_pkg::KindLoad: begin
            if (sts_i.plane_ok) begin
              cmd_o.pix_wr       = 1'b1;
              cmd_o.grad_zero_wr = 1'b1;
            end
          end
          mpae_pkg::KindRead: begin
            if (sts_i.plane_ok) begin
              cmd_o.grad_rd_item = 1'b1;
              state_d            = mpae_pkg::ST_EMIT;
            end
          end
          mpae_pkg::KindPool: begin
            if (sts_i.out_ok) begin
              cmd_o.pool_init = 1'b1;
              state_d         = mpae_pkg::ST_POOL;
            end
          end
          default: begin
            if (sts_i.out_ok) begin
              cmd_o.mask_rd = 1'b1;
              state_d       = mpae_pkg::ST_MRD;
            end
          end
        endcase
      end
      mpae_pkg::ST_POOL: begin
        cmd_o.pool_step = 1'b1;
        if (sts_i.cells_last) state_d = mpae_pkg::ST_DRAIN;
      end
      mpae_pkg::ST_DRAIN: begin
        state_d = mpae_pkg::ST_PFIN;
      end
      mpae_pkg::ST_PFIN: begin
        cmd_o.mask_wr = 1'b1;
        state_d       = mpae_pkg::ST_EMIT;
      end
      mpae_pkg::ST_MRD: begin
        if (sts_i.mask_valid) begin
          cmd_o.grad_rd_mask = 1'b1;
          state_d            = mpae_pkg::ST_GADD;
        end else begin
          state_d = mpae_pkg::ST_IDLE;
        end
      end
      mpae_pkg::ST_GADD: begin
        cmd_o.grad_sat_wr = 1'b1;
        state_d           = mpae_pkg::ST_IDLE;
      end
      mpae_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mpae_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mpae_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/mpae_datapath.sv]
`timescale 1ns / 1ps
module mpae_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mpae_pkg::cmd_t                       cmd_i,
  output mpae_pkg::sts_t                       sts_o,
  input  logic                                 cfg_we_i,
  input  logic [mpae_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [mpae_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic [1:0]                           kind_i,
  input  logic [6:0]                           row_i,
  input  logic [6:0]                           col_i,
  input  logic signed [mpae_pkg::SampleW-1:0]  sample_i,
  input  logic [7:0]                           channel_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [mpae_pkg::SampleW-1:0]  pooled_value_o,
  output logic [mpae_pkg::IndexW-1:0]          winner_index_o,
  output logic                                 winner_valid_o,
  output logic signed [mpae_pkg::GradW-1:0]    gradient_sum_o
);

  localparam int unsigned Aw  = mpae_pkg::PlaneAw;
  localparam int unsigned Gw  = mpae_pkg::GradW;
  localparam int unsigned Sw  = mpae_pkg::SampleW;
  localparam int unsigned Wcw = mpae_pkg::WinCntW;

  // Configuration registers
  logic [3:0] filt_h_q, filt_w_q, stride_r_q, stride_c_q;
  logic [2:0] pad_r_q, pad_c_q;
  logic [6:0] in_h_q, in_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_h_q   <= 4'd2;
      filt_w_q   <= 4'd2;
      stride_r_q <= 4'd2;
      stride_c_q <= 4'd2;
      pad_r_q    <= 3'd0;
      pad_c_q    <= 3'd0;
      in_h_q     <= 7'd64;
      in_w_q     <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpae_pkg::CfgFilterH: filt_h_q   <= cfg_data_i[3:0];
        mpae_pkg::CfgFilterW: filt_w_q   <= cfg_data_i[3:0];
        mpae_pkg::CfgStrideR: stride_r_q <= cfg_data_i[3:0];
        mpae_pkg::CfgStrideC: stride_c_q <= cfg_data_i[3:0];
        mpae_pkg::CfgPadR:    pad_r_q    <= cfg_data_i[2:0];
        mpae_pkg::CfgPadC:    pad_c_q    <= cfg_data_i[2:0];
        mpae_pkg::CfgInH:     in_h_q     <= cfg_data_i;
        mpae_pkg::CfgInW:     in_w_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry: out-of-range settings clamped
  logic [3:0] fh, fw, sh, sw;
  logic [6:0] ih, iw;
  assign fh = (filt_h_q == 4'd0) ? 4'd1 :
              (filt_h_q > 4'(mpae_pkg::MaxFilter)) ? 4'(mpae_pkg::MaxFilter) : filt_h_q;
  assign fw = (filt_w_q == 4'd0) ? 4'd1 :
              (filt_w_q > 4'(mpae_pkg::MaxFilter)) ? 4'(mpae_pkg::MaxFilter) : filt_w_q;
  assign sh = (stride_r_q == 4'd0) ? 4'd1 : stride_r_q;
  assign sw = (stride_c_q == 4'd0) ? 4'd1 : stride_c_q;
  assign ih = (in_h_q == 7'd0) ? 7'd1 :
              (in_h_q > 7'(mpae_pkg::MaxSide)) ? 7'(mpae_pkg::MaxSide) : in_h_q;
  assign iw = (in_w_q == 7'd0) ? 7'd1 :
              (in_w_q > 7'(mpae_pkg::MaxSide)) ? 7'(mpae_pkg::MaxSide) : in_w_q;

  // Plane area, registered ahead of the channel multiply
  logic [12:0] area_q;
  always_ff @(posedge clk_i) area_q <= 13'(ih * iw);

  // Request registers
  logic [1:0]        kind_q;
  logic [6:0]        row_q, col_q;
  logic signed [Sw-1:0] sample_q;
  logic [7:0]        chan_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_take) begin
      kind_q   <= kind_i;
      row_q    <= row_i;
      col_q    <= col_i;
      sample_q <= sample_i;
      chan_q   <= channel_i;
    end
  end

  // Range checks; an output position is valid when pos*stride + filter fits the padded span
  logic [10:0] row_scaled, col_scaled;
  logic [7:0]  span_h, span_w;
  logic        plane_ok, out_ok;
  logic [12:0] item_addr_w;
  logic [Aw-1:0] item_addr;

  assign row_scaled  = 11'(row_q * sh);
  assign col_scaled  = 11'(col_q * sw);
  assign span_h      = 8'(ih) + {4'd0, pad_r_q, 1'b0};
  assign span_w      = 8'(iw) + {4'd0, pad_c_q, 1'b0};
  assign plane_ok    = (row_q < ih) && (col_q < iw);
  assign out_ok      = ((row_scaled + 11'(fh)) <= 11'(span_h)) &&
                       ((col_scaled + 11'(fw)) <= 11'(span_w));
  assign item_addr_w = 13'(row_q[5:0] * iw) + 13'(col_q[5:0]);
  assign item_addr   = item_addr_w[Aw-1:0];

  // Clearing sweep over the gradient store
  logic [Aw-1:0] clr_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // Window walk: counters and window origin
  logic [Wcw-1:0]   wr_q, wc_q;
  logic signed [11:0] br_q, bc_q;
  logic [20:0]      chan_base_q;
  logic             cells_last;
  logic             row_end;

  assign row_end    = (wc_q == Wcw'(fw - 4'd1));
  assign cells_last = row_end && (wr_q == Wcw'(fh - 4'd1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.pool_init) begin
      wr_q        <= '0;
      wc_q        <= '0;
      br_q        <= $signed({1'b0, row_scaled}) - $signed({9'd0, pad_r_q});
      bc_q        <= $signed({1'b0, col_scaled}) - $signed({9'd0, pad_c_q});
      chan_base_q <= 21'(chan_q * area_q);
    end else if (cmd_i.pool_step) begin
      if (row_end) begin
        wc_q <= '0;
        wr_q <= wr_q + 1'b1;
      end else begin
        wc_q <= wc_q + 1'b1;
      end
    end
  end

  // Current cell position and pixel address
  logic signed [11:0] pr, pc;
  logic               cell_in;
  logic [12:0]        cell_addr_w;
  logic [Aw-1:0]      cell_addr;

  assign pr      = br_q + $signed({{(12-Wcw){1'b0}}, wr_q});
  assign pc      = bc_q + $signed({{(12-Wcw){1'b0}}, wc_q});
  assign cell_in = !pr[11] && !pc[11] && (pr[10:0] < 11'(ih)) && (pc[10:0] < 11'(iw));
  assign cell_addr_w = 13'(pr[5:0] * iw) + 13'(pc[5:0]);
  assign cell_addr   = cell_addr_w[Aw-1:0];

  // Pixel store, one port
  logic signed [Sw-1:0] pix_mem [mpae_pkg::PlaneCells];
  logic signed [Sw-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_wr) begin
      pix_mem[item_addr] <= sample_q;
    end else if (cmd_i.pool_step && cell_in) begin
      pix_q <= pix_mem[cell_addr];
    end
  end

  // Cell stage, aligned with the pixel read data
  logic          st_vld_q, st_in_q;
  logic [Aw-1:0] st_plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= cmd_i.pool_step;
    end
  end

  always_ff @(posedge clk_i) begin
    st_in_q    <= cell_in;
    st_plane_q <= cell_addr;
  end

  // Running maximum; strict compare keeps the first winner
  logic signed [Sw-1:0] best_q, cell_val;
  logic                 first_q, win_in_q;
  logic [Aw-1:0]        win_plane_q;

  assign cell_val = st_in_q ? pix_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pool_init) begin
      first_q <= 1'b1;
    end else if (st_vld_q && (first_q || (cell_val > best_q))) begin
      first_q     <= 1'b0;
      best_q      <= cell_val;
      win_in_q    <= st_in_q;
      win_plane_q <= st_plane_q;
    end
  end

  // Argmax mask store: valid bit over plane address
  logic [Aw:0] mask_mem [mpae_pkg::MaskCells];
  logic [Aw:0] mask_q;
  logic [mpae_pkg::MaskAw-1:0] mask_addr;

  assign mask_addr = {row_q, col_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mask_wr) begin
      mask_mem[mask_addr] <= {win_in_q, win_in_q ? win_plane_q : {Aw{1'b0}}};
    end else if (cmd_i.mask_rd) begin
      mask_q <= mask_mem[mask_addr];
    end
  end

  // Gradient store: one write and one read port
  logic signed [Gw-1:0] grad_mem [mpae_pkg::PlaneCells];
  logic signed [Gw-1:0] grad_q, grad_wdata, sat_sum;
  logic [Aw-1:0]        grad_waddr, grad_raddr, gaddr_q;
  logic                 grad_we;
  logic signed [Gw:0]   wide_sum;

  assign wide_sum = {grad_q[Gw-1], grad_q} + (Gw+1)'(sample_q);
  assign sat_sum  = (wide_sum[Gw] != wide_sum[Gw-1]) ?
                    (wide_sum[Gw] ? {1'b1, {(Gw-1){1'b0}}} : {1'b0, {(Gw-1){1'b1}}}) :
                    wide_sum[Gw-1:0];

  assign grad_we    = cmd_i.clr_wr || cmd_i.grad_zero_wr || cmd_i.grad_sat_wr;
  assign grad_waddr = cmd_i.clr_wr ? clr_cnt_q : (cmd_i.grad_sat_wr ? gaddr_q : item_addr);
  assign grad_wdata = cmd_i.grad_sat_wr ? sat_sum : '0;
  assign grad_raddr = cmd_i.grad_rd_mask ? mask_q[Aw-1:0] : item_addr;

  always_ff @(posedge clk_i) begin
    if (grad_we) grad_mem[grad_waddr] <= grad_wdata;
    if (cmd_i.grad_rd_item || cmd_i.grad_rd_mask) grad_q <= grad_mem[grad_raddr];
    if (cmd_i.grad_rd_mask) gaddr_q <= mask_q[Aw-1:0];
  end

  // Output register
  logic                 out_vld_q, out_wvld_q;
  logic signed [Sw-1:0] out_value_q;
  logic [mpae_pkg::IndexW-1:0] out_index_q;
  logic signed [Gw-1:0] out_grad_q;
  logic [20:0]          win_index;

  assign win_index = chan_base_q + 21'(win_plane_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (kind_q == mpae_pkg::KindPool) begin
        out_value_q <= best_q;
        out_index_q <= win_in_q ? win_index[mpae_pkg::IndexW-1:0] : '0;
        out_wvld_q  <= win_in_q;
        out_grad_q  <= '0;
      end else begin
        out_value_q <= '0;
        out_index_q <= '0;
        out_wvld_q  <= 1'b0;
        out_grad_q  <= grad_q;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign pooled_value_o = out_value_q;
  assign winner_index_o = out_index_q;
  assign winner_valid_o = out_wvld_q;
  assign gradient_sum_o = out_grad_q;

  // Status
  assign sts_o.clr_done   = (clr_cnt_q == {Aw{1'b1}});
  assign sts_o.kind       = kind_q;
  assign sts_o.plane_ok   = plane_ok;
  assign sts_o.out_ok     = out_ok;
  assign sts_o.cells_last = cells_last;
  assign sts_o.mask_valid = mask_q[Aw];
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

endmodule

[rtl/max_pool_argmax_engine.sv]
`timescale 1ns / 1ps
// Max pooling with argmax and gradient scatter on one 64x64 plane of signed Q8.8
// pixels. Requests are taken one at a time. A pool request walks the window one
// cell a cycle through the single port of the pixel store. After reset the gradient
// store is cleared, during which no request is taken (register writes are). A result
// waits in an output register while the next request is taken.
module max_pool_argmax_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // row[6:0], col[13:7], sample[29:14], channel[37:30]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // pooled_value[15:0], winner_index[35:16],
                                      // winner_valid[36], gradient_sum[60:37]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);

  mpae_pkg::cmd_t cmd;
  mpae_pkg::sts_t sts;

  logic signed [15:0] pooled_value;
  logic [19:0]        winner_index;
  logic               winner_valid;
  logic signed [23:0] gradient_sum;

  mpae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpae_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (s_axis_tuser),
    .row_i          (s_axis_tdata[6:0]),
    .col_i          (s_axis_tdata[13:7]),
    .sample_i       (s_axis_tdata[29:14]),
    .channel_i      (s_axis_tdata[37:30]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .pooled_value_o (pooled_value),
    .winner_index_o (winner_index),
    .winner_valid_o (winner_valid),
    .gradient_sum_o (gradient_sum)
  );

  assign m_axis_tdata = {3'd0, gradient_sum, winner_valid, winner_index, pooled_value};

  // A result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten while waiting");

  // The pixel store port is never asked for a write and a window read together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.pix_wr && cmd.pool_step))
    else $error("pixel store port conflict");

  // No request is taken while the gradient store is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !s_axis_tready)
    else $error("request taken during clearing");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned IdleLimit = 20000;

  // Result item as carried on the output bus
  typedef struct packed {
    logic [23:0] gsum;
    logic        wvalid;
    logic [19:0] windex;
    logic [15:0] pval;
  } pool_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [6:0]  cfg_data_i = '0;

  max_pool_argmax_engine uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial forever #1 clk_i = ~clk_i;

  // Shadow of the block's registers and stores
  logic [6:0]  regs [8];
  logic [15:0] pix_shadow [mpae_pkg::PlaneCells];
  logic        pix_known [mpae_pkg::PlaneCells];
  int          grad_shadow [mpae_pkg::PlaneCells];
  logic [31:0] mask_shadow [mpae_pkg::MaskCells];
  logic        mask_known [mpae_pkg::MaskCells];
  int unsigned oh, ow;

  pool_res_t   expected_q [$];
  int          errors = 0;
  int          n_pool = 0, n_read = 0, n_sent = 0;
  int          send_idle = 0, recv_idle = 0;
  bit          hold_recv = 1'b0;
  int unsigned quiet = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned fh_e();
    return clampu(regs[mpae_pkg::CfgFilterH] & 15, 1, mpae_pkg::MaxFilter);
  endfunction
  function automatic int unsigned fw_e();
    return clampu(regs[mpae_pkg::CfgFilterW] & 15, 1, mpae_pkg::MaxFilter);
  endfunction
  function automatic int unsigned sh_e();
    return (regs[mpae_pkg::CfgStrideR] & 15) ? regs[mpae_pkg::CfgStrideR] & 15 : 1;
  endfunction
  function automatic int unsigned sw_e();
    return (regs[mpae_pkg::CfgStrideC] & 15) ? regs[mpae_pkg::CfgStrideC] & 15 : 1;
  endfunction
  function automatic int unsigned ih_e();
    return clampu(regs[mpae_pkg::CfgInH], 1, mpae_pkg::MaxSide);
  endfunction
  function automatic int unsigned iw_e();
    return clampu(regs[mpae_pkg::CfgInW], 1, mpae_pkg::MaxSide);
  endfunction

  function automatic int unsigned side_out(int unsigned in, int unsigned pad,
                                           int unsigned filt, int unsigned stride);
    int unsigned span;
    int unsigned n;
    span = in + 2 * pad;
    if (filt > span) return 0;
    n = 1 + (span - filt) / stride;
    return n > mpae_pkg::MaxOutSide ? mpae_pkg::MaxOutSide : n;
  endfunction

  function automatic void geometry_update();
    oh = side_out(ih_e(), regs[mpae_pkg::CfgPadR] & 7, fh_e(), sh_e());
    ow = side_out(iw_e(), regs[mpae_pkg::CfgPadC] & 7, fw_e(), sw_e());
  endfunction

  // Is every plane cell under this output window loaded?
  function automatic bit window_known(int unsigned r, int unsigned c);
    int br, bc, pr, pc;
    br = r * sh_e() - (regs[mpae_pkg::CfgPadR] & 7);
    bc = c * sw_e() - (regs[mpae_pkg::CfgPadC] & 7);
    for (int i = 0; i < fh_e(); i++)
      for (int j = 0; j < fw_e(); j++) begin
        pr = br + i;
        pc = bc + j;
        if (pr >= 0 && pc >= 0 && pr < ih_e() && pc < iw_e())
          if (!pix_known[pr * iw_e() + pc]) return 1'b0;
      end
    return 1'b1;
  endfunction

  // Work out the effect of one request and queue any result
  function automatic void pool_predict(logic [1:0] kind, int unsigned r, int unsigned c,
                                       logic signed [15:0] smp, int unsigned ch);
    pool_res_t res;
    int unsigned ih, iw, addr, plane;
    int br, bc, pr, pc, best, wr, wc, v, s;
    bit first;
    ih = ih_e();
    iw = iw_e();
    res = '0;
    if (kind == mpae_pkg::KindLoad || kind == mpae_pkg::KindRead) begin
      if (r >= ih || c >= iw) return;
      addr = r * iw + c;
      if (kind == mpae_pkg::KindLoad) begin
        pix_shadow[addr] = smp;
        pix_known[addr] = 1'b1;
        grad_shadow[addr] = 0;
      end else begin
        res.gsum = 24'(grad_shadow[addr]);
        expected_q.push_back(res);
        n_read++;
      end
      return;
    end
    if (r >= oh || c >= ow) return;
    if (kind == mpae_pkg::KindPool) begin
      br = r * sh_e() - (regs[mpae_pkg::CfgPadR] & 7);
      bc = c * sw_e() - (regs[mpae_pkg::CfgPadC] & 7);
      best = 0; wr = br; wc = bc; first = 1'b1;
      for (int i = 0; i < fh_e(); i++)
        for (int j = 0; j < fw_e(); j++) begin
          pr = br + i;
          pc = bc + j;
          v = 0;
          if (pr >= 0 && pc >= 0 && pr < ih && pc < iw)
            v = $signed(pix_shadow[pr * iw + pc]);
          if (first || v > best) begin
            best = v; wr = pr; wc = pc; first = 1'b0;
          end
        end
      res.pval = best[15:0];
      mask_known[r * mpae_pkg::MaxOutSide + c] = 1'b1;
      if (wr >= 0 && wc >= 0 && wr < ih && wc < iw) begin
        plane = wr * iw + wc;
        mask_shadow[r * mpae_pkg::MaxOutSide + c] = 32'h8000_0000 | plane;
        res.windex = 20'(ch * ih * iw + plane);
        res.wvalid = 1'b1;
      end else begin
        mask_shadow[r * mpae_pkg::MaxOutSide + c] = 0;
      end
      expected_q.push_back(res);
      n_pool++;
    end else begin
      addr = mask_shadow[r * mpae_pkg::MaxOutSide + c];
      if (!addr[31] || addr[30:0] >= mpae_pkg::PlaneCells) return;
      s = grad_shadow[addr[30:0]] + smp;
      if (s > 8388607) s = 8388607;
      if (s < -8388608) s = -8388608;
      grad_shadow[addr[30:0]] = s;
    end
  endfunction

  // Offer one request and wait until it is taken; valid stays high afterwards
  task automatic send_request(logic [1:0] kind, int unsigned r, int unsigned c,
                              logic [15:0] smp, logic [7:0] ch);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, ch, smp, c[6:0], r[6:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pool_predict(kind, r, c, smp, ch);
    n_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    regs[idx] = val;
    geometry_update();
  endtask

  task automatic set_geometry(int fh, int fw, int sr, int sc, int pr, int pc, int h, int w);
    wait_drained();
    write_reg(mpae_pkg::CfgFilterH, 7'(fh)); write_reg(mpae_pkg::CfgFilterW, 7'(fw));
    write_reg(mpae_pkg::CfgStrideR, 7'(sr)); write_reg(mpae_pkg::CfgStrideC, 7'(sc));
    write_reg(mpae_pkg::CfgPadR, 7'(pr));    write_reg(mpae_pkg::CfgPadC, 7'(pc));
    write_reg(mpae_pkg::CfgInH, 7'(h));      write_reg(mpae_pkg::CfgInW, 7'(w));
    cfg_we_i <= 1'b0;
  endtask

  // Fill the whole active plane with random pixels
  task automatic load_plane();
    for (int r = 0; r < ih_e(); r++)
      for (int c = 0; c < iw_e(); c++)
        send_request(mpae_pkg::KindLoad, r, c, 16'($urandom), 8'($urandom));
  endtask

  // Random mix; pools only over fully loaded windows, adds only where pooled
  task automatic random_mix(int count);
    int unsigned sel, r, c;
    logic [1:0] k;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      k = sel < 15 ? mpae_pkg::KindLoad : sel < 55 ? mpae_pkg::KindPool :
          sel < 80 ? mpae_pkg::KindGrad : mpae_pkg::KindRead;
      if ($urandom_range(9) == 0) begin
        r = $urandom_range(127);
        c = $urandom_range(127);
      end else if (k == mpae_pkg::KindLoad || k == mpae_pkg::KindRead) begin
        r = $urandom_range(ih_e() - 1);
        c = $urandom_range(iw_e() - 1);
      end else begin
        r = oh ? $urandom_range(oh - 1) : 0;
        c = ow ? $urandom_range(ow - 1) : 0;
      end
      if (k == mpae_pkg::KindPool && r < oh && c < ow && !window_known(r, c))
        k = mpae_pkg::KindRead;
      if (k == mpae_pkg::KindGrad && r < oh && c < ow &&
          !mask_known[r * mpae_pkg::MaxOutSide + c])
        k = mpae_pkg::KindPool;
      if (k == mpae_pkg::KindPool && r < oh && c < ow && !window_known(r, c))
        k = mpae_pkg::KindRead;
      if (k == mpae_pkg::KindRead && (r >= ih_e() || c >= iw_e())) begin
        r = r % ih_e(); c = c % iw_e();
      end
      send_request(k, r, c,
                   $urandom_range(3) == 0 ? ($urandom_range(1) ? 16'h7fff : 16'h8000) :
                                            16'($urandom),
                   8'($urandom));
    end
  endtask

  // Directed: extremes, padding winner, ties, saturation, ignored positions
  task automatic test_directed();
    set_geometry(3, 3, 2, 2, 1, 1, 4, 4);
    for (int i = 0; i < 16; i++) send_request(mpae_pkg::KindLoad, i / 4, i % 4, 16'h8000, 8'hff);
    send_request(mpae_pkg::KindPool, 0, 0, 16'h0000, 8'hff);  // all negative: padding wins
    send_request(mpae_pkg::KindGrad, 0, 0, 16'h7fff, 8'h00);  // padding mask: no effect
    send_request(mpae_pkg::KindLoad, 1, 1, 16'h7fff, 8'h00);
    send_request(mpae_pkg::KindPool, 1, 1, 16'h0000, 8'hff);
    for (int i = 0; i < 260; i++) send_request(mpae_pkg::KindGrad, 1, 1, 16'h7fff, 8'h00);
    send_request(mpae_pkg::KindRead, 1, 1, 16'h0000, 8'h00);  // saturated high
    for (int i = 0; i < 520; i++) send_request(mpae_pkg::KindGrad, 1, 1, 16'h8000, 8'h00);
    send_request(mpae_pkg::KindRead, 1, 1, 16'h0000, 8'h00);  // saturated low
    send_request(mpae_pkg::KindPool, 127, 127, 16'hffff, 8'h00);
    send_request(mpae_pkg::KindRead, 127, 127, 16'hffff, 8'h00);
    send_request(mpae_pkg::KindLoad, 4, 0, 16'h1234, 8'h00);
    set_geometry(15, 15, 0, 0, 7, 7, 4, 4);  // out-of-range registers clamp
    send_request(mpae_pkg::KindPool, 0, 0, 16'h0, 8'h00);
    send_request(mpae_pkg::KindGrad, 1, 1, 16'h0100, 8'h00);  // stale mask after geometry change
    send_request(mpae_pkg::KindRead, 1, 1, 16'h0, 8'h00);
    wait_drained();
  endtask

  task automatic test_random(int fh, int fw, int sr, int sc, int pr, int pc, int h, int w,
                             int count);
    set_geometry(fh, fw, sr, sc, pr, pc, h, w);
    load_plane();
    random_mix(count);
  endtask

  // Receiver holds off while requests keep coming, then the sender waits for all
  task automatic test_backpressure();
    set_geometry(2, 2, 1, 1, 0, 0, 6, 6);
    load_plane();
    hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      random_mix(60);
    join
    wait_drained();
  endtask

  // Output side: stall and check
  always @(posedge clk_i) begin
    pool_res_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[60:0];
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.pval !== exp_r.pval)
          begin $display("%0t: pooled_value exp %h got %h", $time, exp_r.pval, got.pval); errors++; end
        if (got.windex !== exp_r.windex)
          begin $display("%0t: winner_index exp %h got %h", $time, exp_r.windex, got.windex); errors++; end
        if (got.wvalid !== exp_r.wvalid)
          begin $display("%0t: winner_valid exp %b got %b", $time, exp_r.wvalid, got.wvalid); errors++; end
        if (got.gsum !== exp_r.gsum)
          begin $display("%0t: gradient_sum exp %h got %h", $time, exp_r.gsum, got.gsum); errors++; end
      end
    end
    m_axis_tready <= !hold_recv && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  // Watchdog on handshake inactivity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    regs = '{7'd2, 7'd2, 7'd2, 7'd2, 7'd0, 7'd0, 7'd64, 7'd64};
    for (int i = 0; i < mpae_pkg::PlaneCells; i++) begin
      grad_shadow[i] = 0; pix_known[i] = 1'b0; pix_shadow[i] = '0;
    end
    for (int i = 0; i < mpae_pkg::MaskCells; i++) begin
      mask_shadow[i] = 0; mask_known[i] = 1'b0;
    end
    geometry_update();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 15; recv_idle = 70;
    test_directed();
    test_random(2, 2, 2, 2, 0, 0, 8, 8, 150);
    test_random(8, 8, 8, 8, 7, 7, 9, 9, 100);
    send_idle = 70; recv_idle = 15;
    test_random(1, 1, 1, 1, 0, 0, 1, 1, 50);
    test_random(3, 5, 1, 3, 2, 0, 7, 12, 150);
    send_idle = 0; recv_idle = 0;
    test_random(4, 2, 3, 1, 1, 3, 10, 5, 200);
    test_backpressure();
    test_random(8, 8, 8, 8, 7, 7, 64, 2, 100);
    wait_drained();
    $display("Sent %0d requests; checked %0d pool and %0d gradient-read results.",
             n_sent, n_pool, n_read);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/mpae_pkg.sv
rtl/mpae_ctrl.sv
rtl/mpae_datapath.sv
rtl/max_pool_argmax_engine.sv
tb/tb_top.sv
